>>> rtl/core/ealt_pkg.sv
// ---------------------------------------------------------------------------
// ealt_pkg
// shared types, codes and sizes for the entity acquire/lock table
// ---------------------------------------------------------------------------
package ealt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int ID_WIDTH            = 64;
   localparam int CONFIG_WIDTH        = 16;
   localparam int KIND_WIDTH          = 3;
   localparam int STATUS_WIDTH        = 3;

   // command codes
   localparam logic [KIND_WIDTH-1:0] KIND_ACQUIRE    = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RELEASE    = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_LOCK       = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_GET_CONFIG = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_SET_CONFIG = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY      = 3'd5;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK               = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ACQUIRED         = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_LOCK_REFUSED     = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_ENTITY        = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_ARGS         = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RELEASE_REFUSED  = 3'd5;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_OWNER  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_RESP   = 5'b10000
   } seq_state_type;

   // sequencer status towards the top level
   typedef struct packed {
      logic idle;
      logic decide;
      logic resp;
      logic found;
   } seq_status_type;

endpackage

>>> rtl/core/ealt_ram.sv
// ---------------------------------------------------------------------------
// ealt_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module ealt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ealt_seq.sv
// ---------------------------------------------------------------------------
// ealt_seq
// search sequencer with the shared 64-bit id comparator
// ---------------------------------------------------------------------------
module ealt_seq #(
   parameter int MAX_ENTRIES = ealt_pkg::MAX_ENTRIES_DEFAULT,
   parameter int ADDR_WIDTH  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   parameter int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          rsp_done,
   input  logic [COUNT_WIDTH-1:0]        entry_count,
   input  logic [ealt_pkg::ID_WIDTH-1:0] entity_rd_data,
   input  logic [ealt_pkg::ID_WIDTH-1:0] owner_rd_data,
   input  logic [ealt_pkg::ID_WIDTH-1:0] target_id,
   input  logic [ealt_pkg::ID_WIDTH-1:0] controller_id,
   output logic [ADDR_WIDTH-1:0]         entity_rd_addr,
   output logic [ADDR_WIDTH-1:0]         hit_idx,
   output logic                          owner_match,
   output ealt_pkg::seq_status_type      seq_status
);

   ealt_pkg::seq_state_type state_ff, state_in;
   logic [COUNT_WIDTH-1:0] ptr_ff, ptr_in;
   logic [ADDR_WIDTH-1:0]  chk_idx_ff, chk_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [ADDR_WIDTH-1:0]  hit_idx_ff, hit_idx_in;
   logic                   found_ff, found_in;

   logic [ealt_pkg::ID_WIDTH-1:0] cmp_a;
   logic [ealt_pkg::ID_WIDTH-1:0] cmp_b;
   logic                          cmp_eq;

   // one comparator: entity ids while scanning, owner id when deciding
   assign cmp_a  = (state_ff == ealt_pkg::ST_SCAN) ? entity_rd_data : owner_rd_data;
   assign cmp_b  = (state_ff == ealt_pkg::ST_SCAN) ? target_id : controller_id;
   assign cmp_eq = (cmp_a == cmp_b);

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = chk_vld_ff;
      hit_idx_in = hit_idx_ff;
      found_in   = found_ff;
      case (state_ff)
         ealt_pkg::ST_IDLE: begin
            if (start) begin
               ptr_in     = '0;
               chk_vld_in = 1'b0;
               found_in   = 1'b0;
               state_in   = ealt_pkg::ST_SCAN;
            end
         end
         ealt_pkg::ST_SCAN: begin
            if (chk_vld_ff && cmp_eq) begin
               found_in   = 1'b1;
               hit_idx_in = chk_idx_ff;
               chk_vld_in = 1'b0;
               state_in   = ealt_pkg::ST_OWNER;
            end else if (ptr_ff < entry_count) begin
               chk_idx_in = ptr_ff[ADDR_WIDTH-1:0];
               chk_vld_in = 1'b1;
               ptr_in     = ptr_ff + 1'b1;
            end else begin
               chk_vld_in = 1'b0;
               state_in   = ealt_pkg::ST_DECIDE;
            end
         end
         ealt_pkg::ST_OWNER: begin
            state_in = ealt_pkg::ST_DECIDE;
         end
         ealt_pkg::ST_DECIDE: begin
            state_in = ealt_pkg::ST_RESP;
         end
         ealt_pkg::ST_RESP: begin
            if (rsp_done) begin
               state_in = ealt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ealt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ealt_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         found_ff   <= found_in;
      end
      ptr_ff     <= ptr_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
   end

   assign entity_rd_addr    = ptr_ff[ADDR_WIDTH-1:0];
   assign hit_idx           = hit_idx_ff;
   assign owner_match       = cmp_eq;
   assign seq_status.idle   = (state_ff == ealt_pkg::ST_IDLE);
   assign seq_status.decide = (state_ff == ealt_pkg::ST_DECIDE);
   assign seq_status.resp   = (state_ff == ealt_pkg::ST_RESP);
   assign seq_status.found  = found_ff;

endmodule

>>> rtl/core/entity_acquire_lock_table_unit.sv
// request transfer to response valid: id scan through the entity ram with its
// registered read, then for a found id the owner read, then the decision
// throughput: one command at a time, the next request is taken in the idle cycle
// after the response transfer
// reset: synchronous, clears the flags, entry count and configuration
// ---------------------------------------------------------------------------
// entity_acquire_lock_table_unit
// acquire, release, lock and configuration table of up to MAX_ENTRIES entities
// ---------------------------------------------------------------------------
module entity_acquire_lock_table_unit #(
   parameter int MAX_ENTRIES = ealt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ealt_pkg::KIND_WIDTH-1:0]      req_kind,
   input  logic [ealt_pkg::ID_WIDTH-1:0]        req_target_entity_id,
   input  logic [ealt_pkg::ID_WIDTH-1:0]        req_controller_entity_id,
   input  logic [ealt_pkg::CONFIG_WIDTH-1:0]    req_configuration_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ealt_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic                                 rsp_is_acquired,
   output logic                                 rsp_is_locked,
   output logic [ealt_pkg::CONFIG_WIDTH-1:0]    rsp_current_configuration
);

   localparam int ADDR_WIDTH  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(MAX_ENTRIES);

   // captured request
   logic [ealt_pkg::KIND_WIDTH-1:0]   kind_ff;
   logic [ealt_pkg::ID_WIDTH-1:0]     target_ff;
   logic [ealt_pkg::ID_WIDTH-1:0]     ctrl_ff;
   logic [ealt_pkg::CONFIG_WIDTH-1:0] cfg_idx_ff;

   // table state
   logic [MAX_ENTRIES-1:0]            acq_flags_ff;
   logic [MAX_ENTRIES-1:0]            lck_flags_ff;
   logic [COUNT_WIDTH-1:0]            count_ff, count_in;
   logic [ealt_pkg::CONFIG_WIDTH-1:0] first_cfg_ff, first_cfg_in;

   // response registers
   logic [ealt_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic                              out_acq_ff, out_acq_in;
   logic                              out_lck_ff, out_lck_in;
   logic [ealt_pkg::CONFIG_WIDTH-1:0] out_cfg_ff, out_cfg_in;

   // sequencer interface
   ealt_pkg::seq_status_type      seq_status;
   logic [ADDR_WIDTH-1:0]         entity_rd_addr;
   logic [ADDR_WIDTH-1:0]         hit_idx;
   logic                          owner_match;
   logic [ealt_pkg::ID_WIDTH-1:0] entity_rd_data;
   logic [ealt_pkg::ID_WIDTH-1:0] owner_rd_data;

   // decision outputs
   logic                  ent_we;
   logic                  own_we;
   logic [ADDR_WIDTH-1:0] flag_idx;
   logic                  set_acq;
   logic                  clr_acq;
   logic                  set_lck;
   logic                  clr_lck;
   logic                  cur_acq;
   logic                  cur_lck;

   logic req_xfer;
   logic rsp_xfer;

   assign req_ready = seq_status.idle;
   assign rsp_valid = seq_status.resp;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // hold the command for the whole search
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff    <= req_kind;
         target_ff  <= req_target_entity_id;
         ctrl_ff    <= req_controller_entity_id;
         cfg_idx_ff <= req_configuration_index;
      end
   end

   ealt_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_WIDTH  (ADDR_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (req_xfer),
      .rsp_done       (rsp_xfer),
      .entry_count    (count_ff),
      .entity_rd_data (entity_rd_data),
      .owner_rd_data  (owner_rd_data),
      .target_id      (target_ff),
      .controller_id  (ctrl_ff),
      .entity_rd_addr (entity_rd_addr),
      .hit_idx        (hit_idx),
      .owner_match    (owner_match),
      .seq_status     (seq_status)
   );

   // entity ids, appended at the current count
   ealt_ram #(
      .WIDTH      (ealt_pkg::ID_WIDTH),
      .DEPTH      (MAX_ENTRIES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_entity_ram (
      .clock   (clock),
      .wr_en   (ent_we && seq_status.decide),
      .wr_addr (flag_idx),
      .wr_data (target_ff),
      .rd_addr (entity_rd_addr),
      .rd_data (entity_rd_data)
   );

   // owning controller ids, only looked at while the acquired flag is set
   ealt_ram #(
      .WIDTH      (ealt_pkg::ID_WIDTH),
      .DEPTH      (MAX_ENTRIES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we && seq_status.decide),
      .wr_addr (flag_idx),
      .wr_data (ctrl_ff),
      .rd_addr (hit_idx),
      .rd_data (owner_rd_data)
   );

   // flags of the entry found by the scan
   assign cur_acq = seq_status.found && acq_flags_ff[hit_idx];
   assign cur_lck = seq_status.found && lck_flags_ff[hit_idx];

   // command decision, evaluated in the single decide cycle
   always_comb begin
      status_in    = ealt_pkg::STATUS_OK;
      out_acq_in   = cur_acq;
      out_lck_in   = cur_lck;
      count_in     = count_ff;
      first_cfg_in = first_cfg_ff;
      ent_we       = 1'b0;
      own_we       = 1'b0;
      flag_idx     = hit_idx;
      set_acq      = 1'b0;
      clr_acq      = 1'b0;
      set_lck      = 1'b0;
      clr_lck      = 1'b0;
      case (kind_ff)
         ealt_pkg::KIND_ACQUIRE: begin
            if (!seq_status.found) begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ealt_pkg::STATUS_ACQUIRED;
               end else begin
                  // append a fresh entry and take it straight away
                  flag_idx   = count_ff[ADDR_WIDTH-1:0];
                  ent_we     = 1'b1;
                  own_we     = 1'b1;
                  set_acq    = 1'b1;
                  clr_lck    = 1'b1;
                  out_acq_in = 1'b1;
                  out_lck_in = 1'b0;
                  count_in   = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     first_cfg_in = '0;
                  end
               end
            end else if (cur_acq && !owner_match) begin
               status_in = ealt_pkg::STATUS_ACQUIRED;
            end else begin
               own_we     = 1'b1;
               set_acq    = 1'b1;
               out_acq_in = 1'b1;
            end
         end
         ealt_pkg::KIND_RELEASE: begin
            if (!seq_status.found) begin
               status_in = ealt_pkg::STATUS_NO_ENTITY;
            end else if (!cur_acq || !owner_match) begin
               status_in = ealt_pkg::STATUS_RELEASE_REFUSED;
            end else begin
               clr_acq    = 1'b1;
               clr_lck    = 1'b1;
               out_acq_in = 1'b0;
               out_lck_in = 1'b0;
            end
         end
         ealt_pkg::KIND_LOCK: begin
            if (!seq_status.found) begin
               status_in = ealt_pkg::STATUS_NO_ENTITY;
            end else if (cur_acq && owner_match) begin
               set_lck    = 1'b1;
               out_lck_in = 1'b1;
            end else begin
               status_in = ealt_pkg::STATUS_LOCK_REFUSED;
            end
         end
         ealt_pkg::KIND_GET_CONFIG: begin
            status_in = ealt_pkg::STATUS_OK;
         end
         ealt_pkg::KIND_SET_CONFIG: begin
            if (count_ff != '0) begin
               first_cfg_in = cfg_idx_ff;
            end else begin
               status_in = ealt_pkg::STATUS_BAD_ARGS;
            end
         end
         ealt_pkg::KIND_QUERY: begin
            status_in = ealt_pkg::STATUS_OK;
         end
         default: begin
            status_in = ealt_pkg::STATUS_BAD_ARGS;
         end
      endcase
      // configuration reads as zero while the table is empty
      out_cfg_in = (count_in != '0) ? first_cfg_in : '0;
   end

   // table state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acq_flags_ff <= '0;
         lck_flags_ff <= '0;
         count_ff     <= '0;
         first_cfg_ff <= '0;
      end else if (seq_status.decide) begin
         count_ff     <= count_in;
         first_cfg_ff <= first_cfg_in;
         if (set_acq) begin
            acq_flags_ff[flag_idx] <= 1'b1;
         end else if (clr_acq) begin
            acq_flags_ff[flag_idx] <= 1'b0;
         end
         if (set_lck) begin
            lck_flags_ff[flag_idx] <= 1'b1;
         end else if (clr_lck) begin
            lck_flags_ff[flag_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_status.decide) begin
         status_ff  <= status_in;
         out_acq_ff <= out_acq_in;
         out_lck_ff <= out_lck_in;
         out_cfg_ff <= out_cfg_in;
      end
   end

   assign rsp_status                = status_ff;
   assign rsp_is_acquired           = out_acq_ff;
   assign rsp_is_locked             = out_lck_ff;
   assign rsp_current_configuration = out_cfg_ff;

endmodule
